/* sv/mlfs_pkg.sv */
`default_nettype none

package mlfs_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned HEIGHT_LIMIT  = 4096;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned FNUM_W     = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned TERM_W     = 11;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_FRAME_HEIGHT = 8'd1
  } cfg_reg_e;

  // Position flags and neighbor values of one pixel, handed from the
  // address stage to the accumulate stage.
  typedef struct packed {
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] prev1;
    logic [PIX_W-1:0] prev2;
    logic             h_on;
    logic             h_two;
    logic             h_end;
    logic             v_on;
    logic             v_two;
    logic             v_end;
    logic             last;
  } pix_info_t;

endpackage

`default_nettype wire

/* sv/mlfs_if.sv */
`default_nettype none

interface mlfs_pix_if import mlfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_blue;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_red;

  modport source (output valid, output pixel_blue, output pixel_green, output pixel_red,
                  input ready);
  modport sink (input valid, input pixel_blue, input pixel_green, input pixel_red,
                output ready);
endinterface

interface mlfs_res_if import mlfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  focus_sum;
  logic [FNUM_W-1:0] frame_number;

  modport source (output valid, output focus_sum, output frame_number, input ready);
  modport sink (input valid, input focus_sum, input frame_number, output ready);
endinterface

interface mlfs_cfg_if import mlfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/modified_laplacian_focus_sum.sv */
// Takes one pixel word per clock while the accumulate stage can pass it on; the line
// memory is read at the accept edge and written back when that pixel word advances.
// The result word is registered when the frame's last pixel word leaves the accumulate
// stage, which waits while the previous result word has not been taken.
// Asynchronous active-low reset clears counters, sum, frame count and
// handshakes; the line memory is not cleared, and no value read from it is used before it is written.
`default_nettype none

module modified_laplacian_focus_sum import mlfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  mlfs_pix_if.sink   pix_i,
  mlfs_cfg_if.sink   cfg_i,
  mlfs_res_if.source res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  pix_info_t          info;
  logic [CW-1:0]      col, waddr;
  logic               load, restart, ready, we;
  logic [2*PIX_W-1:0] rdata, wdata;

  mlfs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .cfg_i     (cfg_i),
    .ready_i   (ready),
    .load_o    (load),
    .info_o    (info),
    .col_o     (col),
    .restart_o (restart)
  );

  mlfs_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (load),
    .raddr_i (col),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  mlfs_accum #(.MAX_WIDTH(MAX_WIDTH)) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .info_i    (info),
    .col_i     (col),
    .restart_i (restart),
    .ready_o   (ready),
    .rdata_i   (rdata),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

/* sv/mlfs_line_mem.sv */
`default_nettype none

module mlfs_line_mem import mlfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         re_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] raddr_i,
  output      logic [2*PIX_W-1:0]           rdata_o,
  input  wire logic                         we_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] waddr_i,
  input  wire logic [2*PIX_W-1:0]           wdata_i
);

  // Each entry holds the older row value above the newer row value.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/mlfs_front.sv */
`default_nettype none

module mlfs_front import mlfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mlfs_pix_if.sink                          pix_i,
  mlfs_cfg_if.sink                          cfg_i,
  input  wire logic                         ready_i,
  output      logic                         load_o,
  output      pix_info_t                    info_o,
  output      logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output      logic                         restart_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [CW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [2*PIX_W-1:0]    left_q, left_d;
  logic [CW-1:0]         wm1;
  logic [ROW_W-1:0]      hm1;
  logic [PIX_W-1:0]      val;
  logic                  cfg_fire, cfg_restart, accept;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign cfg_restart = cfg_fire && (cfg_i.index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});
  assign restart_o   = cfg_restart;
  assign pix_i.ready = ready_i;
  assign accept      = pix_i.valid && ready_i;
  assign load_o      = accept;
  assign col_o       = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_fire) begin
      if (cfg_i.index == CFG_FRAME_WIDTH) begin
        width_q <= cfg_i.data;
      end
      if (cfg_i.index == CFG_FRAME_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  always_comb begin
    if (width_q < 13'd2) begin
      wm1 = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width_q - 13'd1);
    end
    if (height_q < 13'd2) begin
      hm1 = ROW_W'(1);
    end else if (32'(height_q) > HEIGHT_LIMIT) begin
      hm1 = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      hm1 = ROW_W'(height_q - 13'd1);
    end
  end

  always_comb begin
    val = pix_i.pixel_blue;
    if (pix_i.pixel_green > val) begin
      val = pix_i.pixel_green;
    end
    if (pix_i.pixel_red > val) begin
      val = pix_i.pixel_red;
    end

    info_o.val   = val;
    info_o.prev1 = left_q[PIX_W-1:0];
    info_o.prev2 = left_q[2*PIX_W-1:PIX_W];
    info_o.h_on  = (col_q != '0);
    info_o.h_two = (col_q != '0) && (col_q != CW'(1));
    info_o.h_end = (col_q == wm1);
    info_o.v_on  = (row_q != '0);
    info_o.v_two = (row_q != '0) && (row_q != ROW_W'(1));
    info_o.v_end = (row_q == hm1);
    info_o.last  = info_o.h_end && info_o.v_end;

    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (cfg_restart) begin
      col_d  = '0;
      row_d  = '0;
      left_d = '0;
    end else if (accept) begin
      left_d = {left_q[PIX_W-1:0], val};
      if (info_o.h_end) begin
        col_d = '0;
        row_d = info_o.v_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

/* sv/mlfs_accum.sv */
`default_nettype none

module mlfs_accum import mlfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire pix_info_t                    info_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  wire logic                         restart_i,
  output      logic                         ready_o,
  input  wire logic [2*PIX_W-1:0]           rdata_i,
  output      logic                         we_o,
  output      logic [$clog2(MAX_WIDTH)-1:0] waddr_o,
  output      logic [2*PIX_W-1:0]           wdata_o,
  mlfs_res_if.source                        res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  function automatic logic [PIX_W:0] absdiff(input logic [PIX_W:0] a, input logic [PIX_W:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  pix_info_t         s1_q;
  logic [CW-1:0]     col_q;
  logic              s1_valid_q;
  logic              advance;
  logic [PIX_W-1:0]  mid, up;
  logic [PIX_W:0]    h_main, h_edge, v_main, v_edge;
  logic [PIX_W-1:0]  h_left, v_up;
  logic [TERM_W-1:0] acc;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  out_sum_q;
  logic [FNUM_W-1:0] out_num_q, frame_q;
  logic              out_valid_q;

  assign mid = rdata_i[PIX_W-1:0];
  assign up  = rdata_i[2*PIX_W-1:PIX_W];

  assign advance = s1_valid_q && (!s1_q.last || !out_valid_q || res_o.ready);
  assign ready_o = !s1_valid_q || advance;

  assign we_o    = advance;
  assign waddr_o = col_q;
  assign wdata_o = {mid, s1_q.val};

  always_comb begin
    h_left = s1_q.h_two ? s1_q.prev2 : s1_q.val;
    v_up   = s1_q.v_two ? up : s1_q.val;
    h_main = absdiff({s1_q.prev1, 1'b0}, {1'b0, h_left} + {1'b0, s1_q.val});
    h_edge = absdiff({1'b0, s1_q.val}, {1'b0, s1_q.prev1});
    v_main = absdiff({mid, 1'b0}, {1'b0, v_up} + {1'b0, s1_q.val});
    v_edge = absdiff({1'b0, s1_q.val}, {1'b0, mid});
    acc = '0;
    if (s1_q.h_on) begin
      acc = acc + {2'b0, h_main};
      if (s1_q.h_end) begin
        acc = acc + {1'b0, h_edge, 1'b0};
      end
    end
    if (s1_q.v_on) begin
      acc = acc + {2'b0, v_main};
      if (s1_q.v_end) begin
        acc = acc + {1'b0, v_edge, 1'b0};
      end
    end
    sum_d = sum_q + {{(SUM_W-TERM_W){1'b0}}, acc};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q  <= info_i;
      col_q <= col_i;
    end
    if (advance && s1_q.last) begin
      out_sum_q <= sum_d;
      out_num_q <= frame_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (restart_i) begin
        sum_q <= '0;
      end else if (advance) begin
        sum_q <= s1_q.last ? '0 : sum_d;
      end
      if (advance && s1_q.last) begin
        out_valid_q <= 1'b1;
        frame_q     <= frame_q + FNUM_W'(1);
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.focus_sum    = out_sum_q;
  assign res_o.frame_number = out_num_q;

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench import mlfs_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS  = 460;
  localparam int unsigned RANDOM_SUMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;

  localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_HIGH = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bgr_t;

  typedef struct packed {
    logic [SUM_W-1:0]  focus_sum;
    logic [FNUM_W-1:0] frame_number;
  } focus_result_t;

  typedef enum {GAPS_NONE, GAPS_LIGHT, GAPS_FULL} gap_style_e;
  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_SINGLE} pixel_mode_e;

  // Tracks the frame position, both line rows and the running sum, and keeps
  // the focus results that accepted pixel words are due to produce.
  class focus_checker;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [PIX_W-1:0]      older_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]      newer_row [MAX_WIDTH_DEF];
    logic [2*PIX_W-1:0]    left_pair;
    int unsigned           column;
    int unsigned           row;
    logic [SUM_W:0]        frame_sum;
    logic [FNUM_W-1:0]     frame_index;
    focus_result_t         pending [$];
    int unsigned           failures;
    int unsigned           results_seen;

    function new();
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      left_pair    = '0;
      column       = 0;
      row          = 0;
      frame_sum    = '0;
      frame_index  = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 2) return 2;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    function int unsigned distance(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void take_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_FRAME_WIDTH: width_reg = value;
        CFG_FRAME_HEIGHT: height_reg = value;
        default: return;
      endcase
      // Any known register write restarts the frame; the frame index stays.
      left_pair = '0;
      column    = 0;
      row       = 0;
      frame_sum = '0;
    endfunction

    function void take_pixel(bgr_t p);
      int unsigned w, h, v, p1, p2, left, mid, up, acc;
      focus_result_t done;
      w   = eff_width();
      h   = eff_height();
      v   = p.blue;
      if (p.green > v) v = p.green;
      if (p.red > v) v = p.red;
      p1  = left_pair[PIX_W-1:0];
      p2  = left_pair[2*PIX_W-1:PIX_W];
      acc = 0;
      if (column >= 1) begin
        left = (column >= 2) ? p2 : v;
        acc += distance(2 * p1, left + v);
        if (column == w - 1) acc += 2 * distance(v, p1);
      end
      if (row >= 1) begin
        mid = newer_row[column];
        up  = (row >= 2) ? older_row[column] : v;
        acc += distance(2 * mid, up + v);
        if (row == h - 1) acc += 2 * distance(v, mid);
      end
      older_row[column] = newer_row[column];
      newer_row[column] = PIX_W'(v);
      left_pair = {left_pair[PIX_W-1:0], PIX_W'(v)};
      frame_sum += acc;
      if (column + 1 >= w) begin
        column = 0;
        if (row + 1 >= h) begin
          done.focus_sum    = frame_sum[SUM_W-1:0];
          done.frame_number = frame_index;
          pending.push_back(done);
          frame_index++;
          frame_sum = '0;
          row       = 0;
        end else begin
          row++;
        end
      end else begin
        column++;
      end
    endfunction

    function void check_sum(logic [SUM_W-1:0] sum, logic [FNUM_W-1:0] number);
      focus_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result word: focus_sum %0d frame_number %0d", sum, number);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (sum !== want.focus_sum) begin
        $error("focus_sum expected %0d, actual %0d", want.focus_sum, sum);
        failures++;
      end
      if (number !== want.frame_number) begin
        $error("frame_number expected %0d, actual %0d", want.frame_number, number);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mlfs_pix_if pix ();
  mlfs_cfg_if cfg ();
  mlfs_res_if res ();

  modified_laplacian_focus_sum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  focus_checker board = new();
  gap_style_e   gap_style = GAPS_FULL;
  int unsigned  holds_requested = 0;
  int unsigned  pixel_count = 0;
  int unsigned  setting_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (gap_style)
      GAPS_NONE: return 0;
      GAPS_LIGHT: return (roll < 90) ? 0 : 1;
      default: begin
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
    endcase
  endfunction

  task automatic send_pixel(input bgr_t p);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.pixel_blue  <= p.blue;
    pix.pixel_green <= p.green;
    pix.pixel_red   <= p.red;
    do @(posedge clk_i); while (!pix.ready);
    board.take_pixel(p);
    pixel_count++;
  endtask

  task automatic send_pixels(input int unsigned count, input pixel_mode_e mode);
    bgr_t p;
    for (int unsigned i = 0; i < count; i++) begin
      case (mode)
        PIX_EXTREME: begin
          p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        PIX_SINGLE: begin
          p = '0;
          case ($urandom_range(0, 2))
            0: p.blue = $urandom;
            1: p.green = $urandom;
            default: p.red = $urandom;
          endcase
        end
        default: p = 24'($urandom);
      endcase
      send_pixel(p);
    end
  endtask

  task automatic settle();
    pix.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high so that back-to-back writes need one assignment per edge.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    board.take_register(index, value);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input bit write_w, input bit write_h);
    settle();
    if (write_w) write_register(CFG_FRAME_WIDTH, w);
    if (write_h) write_register(CFG_FRAME_HEIGHT, h);
    cfg.valid <= 1'b0;
    setting_count++;
  endtask

  initial begin : result_sink
    int unsigned stall_left, hold_left, holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) board.check_sum(res.focus_sum, res.frame_number);
      if (hold_left == 0 && holds_done < holds_requested) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    bgr_t corner_pixels [9];
    logic [CFG_DATA_W-1:0] w, h;
    int unsigned roll, frames, random_start, sums_start;
    pixel_mode_e mode;

    rst_ni          <= 1'b0;
    pix.valid       <= 1'b0;
    pix.pixel_blue  <= '0;
    pix.pixel_green <= '0;
    pix.pixel_red   <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= CFG_FRAME_WIDTH;
    cfg.data        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes on a 3x3 frame.
    corner_pixels = '{'{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
                      '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00},
                      '{8'h80, 8'h7F, 8'h01}, '{8'h00, 8'h00, 8'h00}, '{8'hFE, 8'h01, 8'h7F}};
    configure(13'd3, 13'd3, 1'b1, 1'b1);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);

    // A write in the middle of a frame restarts it; sizes below two act as two.
    send_pixels(2, PIX_EXTREME);
    configure(13'd1, 13'd0, 1'b1, 1'b1);
    send_pixels(4, PIX_EXTREME);

    // Writes to unknown indexes change nothing, not even the frame position.
    send_pixels(2, PIX_RANDOM);
    settle();
    write_register(UNUSED_INDEX_LOW, 13'h1FFF);
    write_register(UNUSED_INDEX_HIGH, 13'h0000);
    cfg.valid <= 1'b0;
    send_pixels(2, PIX_RANDOM);

    random_start = pixel_count;
    sums_start   = board.results_seen;
    while (pixel_count - random_start < RANDOM_ITEMS ||
           board.results_seen - sums_start < RANDOM_SUMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        w = $urandom_range(2, 6);
        h = $urandom_range(2, 5);
      end else if (roll < 90) begin
        w = $urandom_range(7, 16);
        h = $urandom_range(2, 4);
      end else begin
        w = $urandom_range(17, 64);
        h = 13'd2;
      end
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1);
      roll = $urandom_range(0, 9);
      configure(w, h, roll < 8, roll < 6 || roll >= 8);
      gap_style = ($urandom_range(0, 4) == 0) ? GAPS_NONE : GAPS_FULL;
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        mode = pixel_mode_e'($urandom_range(0, 2));
        send_pixels(board.frame_pixels(), mode);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_pixels($urandom_range(1, board.frame_pixels() - 1), PIX_RANDOM);
      end
    end

    // The sink holds off long enough that buffered results back up into the input.
    configure(13'd2, 13'd2, 1'b1, 1'b1);
    gap_style = GAPS_NONE;
    holds_requested++;
    for (int unsigned f = 0; f < 40; f++) send_pixels(4, PIX_EXTREME);

    settle();
    $display("Sent %0d pixel words and checked %0d focus results over %0d frame settings,",
             pixel_count, board.results_seen, setting_count);
    $display("with clamped sizes, mid-frame restarts, unused indexes and a long output stall.");
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
